@@ sv/drpu_pkg.sv @@
// ----------------------------------------------------------------------------
// drpu_pkg
// Shared types and constants for the dead-reckoning pose update block:
// command codes, register indexes, datapath widths and the CORDIC angle table.
// ----------------------------------------------------------------------------
package drpu_pkg;

	// Command codes; the unused codes behave as park.
	localparam logic [2:0] OP_PARK    = 3'd0;
	localparam logic [2:0] OP_DRIVE   = 3'd1;
	localparam logic [2:0] OP_REVERSE = 3'd2;
	localparam logic [2:0] OP_RIGHT   = 3'd3;
	localparam logic [2:0] OP_LEFT    = 3'd4;

	// Configuration register indexes.
	localparam int          CFG_IDX_W      = 2;
	localparam logic [1:0]  REG_TARGET_X   = 2'd0;
	localparam logic [1:0]  REG_TARGET_Y   = 2'd1;
	localparam logic [1:0]  REG_TOLERANCE  = 2'd2;
	localparam logic [15:0] TOL_RESET      = 16'd128;
	localparam logic [15:0] HEADING_RESET  = 16'd16384;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 27;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// CORDIC datapath.
	localparam int                    CORDIC_X_W  = 34;
	localparam int                    CORDIC_Z_W  = 33;
	localparam int                    CS_W        = 27;
	localparam int                    ATAN_DEPTH  = 24;
	localparam int                    ATAN_IDX_W  = 5;
	localparam int                    ATAN_W      = 31;
	localparam logic [CORDIC_X_W-1:0] CORDIC_X0   = 34'd652032874;

	// Delta accumulator: product sum with 30 fraction bits.
	localparam int ACC_W    = 60;
	localparam int ACC_FRAC = 30;

	// Degrees (Q9.7) to binary angle: divide by 45 through a reciprocal.
	localparam logic [MUL_B_W-1:0] DIV45_MULT  = 27'd11930465;
	localparam int                 DIV45_SHIFT = 29;
	localparam int                 TURN_Q_W    = 17;

	typedef struct packed {
		logic                   done;
		logic signed [CS_W-1:0] cos_v;
		logic signed [CS_W-1:0] sin_v;
	} cordic_res_t;

	function automatic logic [ATAN_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
		case (idx)
			5'd0:    return 31'd536870912;
			5'd1:    return 31'd316933406;
			5'd2:    return 31'd167458907;
			5'd3:    return 31'd85004756;
			5'd4:    return 31'd42667331;
			5'd5:    return 31'd21354465;
			5'd6:    return 31'd10679838;
			5'd7:    return 31'd5340245;
			5'd8:    return 31'd2670163;
			5'd9:    return 31'd1335087;
			5'd10:   return 31'd667544;
			5'd11:   return 31'd333772;
			5'd12:   return 31'd166886;
			5'd13:   return 31'd83443;
			5'd14:   return 31'd41722;
			5'd15:   return 31'd20861;
			5'd16:   return 31'd10430;
			5'd17:   return 31'd5215;
			5'd18:   return 31'd2608;
			5'd19:   return 31'd1304;
			5'd20:   return 31'd652;
			5'd21:   return 31'd326;
			5'd22:   return 31'd163;
			5'd23:   return 31'd81;
			default: return 31'd0;
		endcase
	endfunction

endpackage

@@ sv/drpu_mul.sv @@
// ----------------------------------------------------------------------------
// drpu_mul
// Shared signed multiplier with a registered product. Used in turn for the
// travel product, the four partial products of the position deltas and the
// reciprocal division of the turn angle.
// ----------------------------------------------------------------------------
module drpu_mul (
	input  logic                                  clk,
	input  logic signed [drpu_pkg::MUL_A_W-1:0]   a,
	input  logic signed [drpu_pkg::MUL_B_W-1:0]   b,
	output logic signed [drpu_pkg::MUL_P_W-1:0]   prod
);

	logic signed [drpu_pkg::MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

@@ sv/drpu_cordic.sv @@
// ----------------------------------------------------------------------------
// drpu_cordic
// Iterative CORDIC rotation: one micro-rotation per cycle through a shared
// shifter and adder pair, then rounding of cosine and sine to 24 fraction bits.
// ----------------------------------------------------------------------------
module drpu_cordic #(
	parameter int STEPS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [15:0]            angle,
	output drpu_pkg::cordic_res_t  res
);

	localparam int XW     = drpu_pkg::CORDIC_X_W;
	localparam int ZW     = drpu_pkg::CORDIC_Z_W;
	localparam int CW     = drpu_pkg::CS_W;
	localparam int IW     = drpu_pkg::ATAN_IDX_W;
	localparam int NSTEPS = (STEPS < drpu_pkg::ATAN_DEPTH) ? STEPS : drpu_pkg::ATAN_DEPTH;

	localparam logic signed [ZW-1:0] QUARTER = 33'sd1073741824;
	localparam logic signed [ZW-1:0] HALF    = 33'sd2147483648;

	logic                 busy_q;
	logic [IW-1:0]        i_q;
	logic                 done_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic                 neg_q;
	logic signed [CW-1:0] cos_q;
	logic signed [CW-1:0] sin_q;

	logic signed [ZW-1:0] z_init;
	logic signed [ZW-1:0] z_fold;
	logic                 neg_fold;
	logic signed [XW-1:0] x_sh;
	logic signed [XW-1:0] y_sh;
	logic signed [ZW-1:0] atan_z;
	logic signed [XW-1:0] x_rnd;
	logic signed [XW-1:0] y_rnd;
	logic signed [CW-1:0] cos_r;
	logic signed [CW-1:0] sin_r;

	// Fold the angle into the right half-plane; the result is negated later.
	always_comb begin
		z_init   = ZW'($signed({angle, 16'h0000}));
		z_fold   = z_init;
		neg_fold = 1'b0;
		if (z_init > QUARTER) begin
			z_fold   = z_init - HALF;
			neg_fold = 1'b1;
		end else if (z_init < -QUARTER) begin
			z_fold   = z_init + HALF;
			neg_fold = 1'b1;
		end
	end

	assign x_sh   = x_q >>> i_q;
	assign y_sh   = y_q >>> i_q;
	assign atan_z = ZW'(drpu_pkg::atan_val(i_q));
	assign x_rnd  = (x_q + XW'(32)) >>> 6;
	assign y_rnd  = (y_q + XW'(32)) >>> 6;
	assign cos_r  = CW'(x_rnd);
	assign sin_r  = CW'(y_rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == IW'(NSTEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= drpu_pkg::CORDIC_X0;
			y_q   <= '0;
			z_q   <= z_fold;
			neg_q <= neg_fold;
		end else if (busy_q) begin
			if (i_q != IW'(NSTEPS)) begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - atan_z;
				end else begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + atan_z;
				end
			end else begin
				cos_q <= neg_q ? -cos_r : cos_r;
				sin_q <= neg_q ? -sin_r : sin_r;
			end
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = cos_q;
	assign res.sin_v = sin_q;

endmodule

@@ sv/dead_reckoning_pose_update.sv @@
// ----------------------------------------------------------------------------
// dead_reckoning_pose_update
// Planar pose tracker: drive, reverse, turn or park commands update a
// saturating Q24.8 position and a wrapping binary-angle heading, and each
// command returns the pose and a latched arrival flag.
// From accept to result: drive or reverse runs the travel product, the CORDIC rotation
// (CORDIC_STEPS micro-rotations, capped at 24) and the four partial products on the
// shared multiplier; turn converts the angle; after arrival a command skips to the result.
// One command at a time: the next is accepted after the result is loaded.
// Reset (asynchronous, active low): pose 0 at 90 degrees, arrival clear, targets 0,
// tolerance 0.5; no clearing pass.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_update #(
	parameter int CORDIC_STEPS = 16,
	parameter int POS_WIDTH    = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [drpu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        op,
	input  logic [15:0]                       speed,
	input  logic [15:0]                       duration,
	input  logic signed [16:0]                turn_angle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                pos_x,
	output logic signed [31:0]                pos_y,
	output logic [15:0]                       heading,
	output logic                              arrived
);

	localparam int AW   = drpu_pkg::ACC_W;
	localparam int MA   = drpu_pkg::MUL_A_W;
	localparam int MB   = drpu_pkg::MUL_B_W;
	localparam int DLW  = AW - drpu_pkg::ACC_FRAC;
	localparam int SW   = ((POS_WIDTH > DLW) ? POS_WIDTH : DLW) + 1;
	localparam int DW   = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;
	localparam int EW   = (POS_WIDTH > 32) ? POS_WIDTH : 32;
	localparam int QW   = drpu_pkg::TURN_Q_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULP,
		S_ROT,
		S_MXL,
		S_MXH,
		S_MYL,
		S_MYH,
		S_MYE,
		S_PY,
		S_TURN,
		S_TADD,
		S_CHK,
		S_DONE
	} state_t;

	state_t                      state_q;
	logic signed [POS_WIDTH-1:0] px_q;
	logic signed [POS_WIDTH-1:0] py_q;
	logic [15:0]                 hdg_q;
	logic                        reached_q;
	logic                        out_valid_q;

	logic signed [31:0]          target_x_q;
	logic signed [31:0]          target_y_q;
	logic [15:0]                 tol_q;

	logic [2:0]                  op_q;
	logic [15:0]                 speed_q;
	logic [15:0]                 dur_q;
	logic signed [16:0]          turn_q;
	logic [31:0]                 p_q;
	logic signed [AW-1:0]        acc_q;
	logic signed [31:0]          out_x_q;
	logic signed [31:0]          out_y_q;
	logic [15:0]                 out_hdg_q;
	logic                        out_arr_q;

	logic                        in_xfer;
	logic                        out_free;
	logic                        cordic_start;
	logic [15:0]                 cordic_angle;
	drpu_pkg::cordic_res_t       cres;

	logic signed [MA-1:0]                 mul_a;
	logic signed [MB-1:0]                 mul_b;
	logic signed [drpu_pkg::MUL_P_W-1:0]  prod;
	logic signed [AW-1:0]                 prod_ext;
	logic signed [AW-1:0]                 round_c;

	logic signed [DLW-1:0]       delta;
	logic signed [POS_WIDTH-1:0] pos_sel;
	logic signed [SW-1:0]        pos_sum;
	logic                        pos_ovf;
	logic signed [POS_WIDTH-1:0] pos_sat;

	logic [16:0]                 t_mag;
	logic [22:0]                 t_num;
	logic [QW-1:0]               t_quo;
	logic                        t_sub;

	logic signed [DW-1:0]        dx;
	logic signed [DW-1:0]        dy;
	logic [DW-1:0]               dx_mag;
	logic [DW-1:0]               dy_mag;
	logic                        in_window;
	logic signed [EW-1:0]        px_ext;
	logic signed [EW-1:0]        py_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Reverse runs along the opposite heading: add half a turn.
	assign cordic_start = (state_q == S_MULP);
	assign cordic_angle = (op_q == drpu_pkg::OP_REVERSE) ? {~hdg_q[15], hdg_q[14:0]} : hdg_q;

	drpu_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (cordic_angle),
		.res    (cres)
	);

	// Turn: binary angle = (|t| * 64 + 22) / 45, by reciprocal multiplication.
	assign t_mag = turn_q[16] ? 17'(-turn_q) : 17'(turn_q);
	assign t_num = {t_mag, 6'b000000} + 23'd22;
	assign t_quo = prod[drpu_pkg::DIV45_SHIFT +: QW];
	assign t_sub = turn_q[16] ^ (op_q == drpu_pkg::OP_RIGHT);

	always_comb begin
		case (state_q)
			S_MXL, S_MYL: mul_a = MA'({1'b0, p_q[15:0]});
			S_MXH, S_MYH: mul_a = MA'({1'b0, p_q[31:16]});
			S_TURN:       mul_a = MA'({1'b0, t_num});
			default:      mul_a = MA'({1'b0, speed_q});
		endcase
		case (state_q)
			S_MXL, S_MXH: mul_b = cres.cos_v;
			S_MYL, S_MYH: mul_b = cres.sin_v;
			S_TURN:       mul_b = drpu_pkg::DIV45_MULT;
			default:      mul_b = MB'({1'b0, dur_q});
		endcase
	end

	drpu_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign prod_ext = AW'(prod);
	assign round_c  = AW'(64'sd536870912);

	// One shared add and saturate for both axes.
	assign delta   = acc_q[AW-1:drpu_pkg::ACC_FRAC];
	assign pos_sel = (state_q == S_PY) ? py_q : px_q;
	assign pos_sum = SW'(pos_sel) + SW'(delta);
	assign pos_ovf = (pos_sum[SW-1:POS_WIDTH-1] != {(SW-POS_WIDTH+1){pos_sum[SW-1]}});
	assign pos_sat = pos_ovf ? {pos_sum[SW-1], {(POS_WIDTH-1){~pos_sum[SW-1]}}}
	                         : pos_sum[POS_WIDTH-1:0];

	// Arrival window, inclusive on both axes.
	assign dx        = DW'(px_q) - DW'(target_x_q);
	assign dy        = DW'(py_q) - DW'(target_y_q);
	assign dx_mag    = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign dy_mag    = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign in_window = (dx_mag <= DW'(tol_q)) && (dy_mag <= DW'(tol_q));

	assign px_ext = EW'(px_q);
	assign py_ext = EW'(py_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= '0;
			tol_q      <= drpu_pkg::TOL_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				drpu_pkg::REG_TARGET_X:  target_x_q <= cfg_wdata;
				drpu_pkg::REG_TARGET_Y:  target_y_q <= cfg_wdata;
				drpu_pkg::REG_TOLERANCE: tol_q      <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			px_q        <= '0;
			py_q        <= '0;
			hdg_q       <= drpu_pkg::HEADING_RESET;
			reached_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A result waiting in S_DONE reloads the output register itself.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (reached_q) begin
							state_q <= S_DONE;
						end else begin
							case (op)
								drpu_pkg::OP_DRIVE, drpu_pkg::OP_REVERSE: state_q <= S_MULP;
								drpu_pkg::OP_RIGHT, drpu_pkg::OP_LEFT:    state_q <= S_TURN;
								default:                                  state_q <= S_CHK;
							endcase
						end
					end
				end
				S_MULP: state_q <= S_ROT;
				S_ROT: begin
					if (cres.done) begin
						state_q <= S_MXL;
					end
				end
				S_MXL: state_q <= S_MXH;
				S_MXH: state_q <= S_MYL;
				S_MYL: state_q <= S_MYH;
				S_MYH: begin
					px_q    <= pos_sat;
					state_q <= S_MYE;
				end
				S_MYE: state_q <= S_PY;
				S_PY: begin
					py_q    <= pos_sat;
					state_q <= S_CHK;
				end
				S_TURN: state_q <= S_TADD;
				S_TADD: begin
					hdg_q   <= t_sub ? (hdg_q - t_quo[15:0]) : (hdg_q + t_quo[15:0]);
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (in_window) begin
						reached_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= op;
			speed_q <= speed;
			dur_q   <= duration;
			turn_q  <= turn_angle;
		end
		case (state_q)
			S_ROT: p_q   <= prod[31:0];
			S_MXH: acc_q <= prod_ext + round_c;
			S_MYL: acc_q <= acc_q + (prod_ext <<< 16);
			S_MYH: acc_q <= prod_ext + round_c;
			S_MYE: acc_q <= acc_q + (prod_ext <<< 16);
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			out_x_q   <= px_ext[31:0];
			out_y_q   <= py_ext[31:0];
			out_hdg_q <= hdg_q;
			out_arr_q <= reached_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = out_x_q;
	assign pos_y     = out_y_q;
	assign heading   = out_hdg_q;
	assign arrived   = out_arr_q;

endmodule

@@ sv/drpu_checker.sv @@
// ----------------------------------------------------------------------------
// drpu_checker
// Port-level checks for the pose update block: one command in flight, no result
// without a command, stalled results held and the pose frozen once arrival is reported.
// ----------------------------------------------------------------------------
module drpu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic [15:0]        heading,
	input logic               arrived
);

	logic [1:0]         cnt_q;
	logic               seen_arr_q;
	logic signed [31:0] last_x_q;
	logic signed [31:0] last_y_q;
	logic [15:0]        last_h_q;
	logic               in_xfer;
	logic               out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Commands taken but whose result transfer has not yet happened.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= 2'd0;
			seen_arr_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, in_xfer} - {1'b0, out_xfer};
			if (out_xfer && arrived) begin
				seen_arr_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			last_x_q <= pos_x;
			last_y_q <= pos_y;
			last_h_q <= heading;
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken again straight after a transfer");

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q != 2'd0))
		else $error("result offered without an outstanding command");

	a_arrival_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && seen_arr_q) |->
		(arrived && pos_x == last_x_q && pos_y == last_y_q && heading == last_h_q))
		else $error("pose changed after arrival was reported");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pos_x) && $stable(arrived)))
		else $error("stalled result dropped or changed");

endmodule

bind dead_reckoning_pose_update drpu_checker u_drpu_checker (.*);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dead-reckoning pose update block. Commands go in
// over a valid/ready channel in random bursts and each reported pose is
// compared with a cycle-free model of the odometry: CORDIC sine and cosine,
// saturating position, wrapping heading and the latched arrival window.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          ROT_STEPS = 16;
	localparam logic [15:0] HALF_TURN = 16'h8000;
	localparam longint      POS_MAX   = 64'sd2147483647;
	localparam longint      POS_MIN   = -64'sd2147483648;
	localparam longint      ROT_ANGLE [16] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861
	};

	typedef struct packed {
		logic [2:0]         op;
		logic [15:0]        speed;
		logic [15:0]        duration;
		logic signed [16:0] turn_angle;
	} pose_cmd_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] hdg;
		logic        arr;
	} pose_rpt_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_wr_en  = 1'b0;
	logic [1:0]         cfg_index  = '0;
	logic [31:0]        cfg_wdata  = '0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [2:0]         op         = '0;
	logic [15:0]        speed      = '0;
	logic [15:0]        duration   = '0;
	logic signed [16:0] turn_angle = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [15:0]        heading;
	logic               arrived;

	dead_reckoning_pose_update dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Tracked pose and register copies.
	longint      trk_x, trk_y;
	logic [15:0] trk_hdg;
	bit          trk_arrived;
	longint      goal_x, goal_y, goal_tol;

	pose_cmd_t cmd_q [$];
	pose_rpt_t pose_q [$];
	int        fail_count = 0;
	int        results_seen = 0;

	function automatic longint clamp_pos(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic void heading_sincos(input logic [15:0] ang, output longint c,
			output longint s);
		longint z, x, y, nx, ny;
		bit     flip;
		z = longint'($signed({ang, 16'h0000}));
		x = 652032874;
		y = 0;
		flip = 1'b0;
		// Fold the angle into the right half plane; the result is negated after.
		if (z > 64'sd1073741824) begin
			z = z - 64'sd2147483648;
			flip = 1'b1;
		end else if (z < -64'sd1073741824) begin
			z = z + 64'sd2147483648;
			flip = 1'b1;
		end
		for (int i = 0; i < ROT_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - ROT_ANGLE[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + ROT_ANGLE[i];
			end
			x = nx;
			y = ny;
		end
		c = (x + 32) >>> 6;
		s = (y + 32) >>> 6;
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function automatic void travel(input logic [15:0] ang, input logic [15:0] spd,
			input logic [15:0] dur);
		longint p, c, s;
		p = longint'(spd) * longint'(dur);
		heading_sincos(ang, c, s);
		trk_x = clamp_pos(trk_x + ((p * c + 64'sd536870912) >>> 30));
		trk_y = clamp_pos(trk_y + ((p * s + 64'sd536870912) >>> 30));
	endfunction

	function automatic pose_rpt_t advance_pose(input pose_cmd_t cmd);
		longint    t, b;
		pose_rpt_t r;
		if (!trk_arrived) begin
			case (cmd.op)
				drpu_pkg::OP_DRIVE:   travel(trk_hdg, cmd.speed, cmd.duration);
				drpu_pkg::OP_REVERSE: travel(trk_hdg + HALF_TURN, cmd.speed, cmd.duration);
				drpu_pkg::OP_RIGHT, drpu_pkg::OP_LEFT: begin
					t = longint'($signed(cmd.turn_angle));
					b = (magnitude(t) * 64 + 22) / 45;
					if (t < 0)
						b = -b;
					if (cmd.op == drpu_pkg::OP_RIGHT)
						b = -b;
					trk_hdg = trk_hdg + b[15:0];
				end
				default: ;
			endcase
			if (magnitude(trk_x - goal_x) <= goal_tol && magnitude(trk_y - goal_y) <= goal_tol)
				trk_arrived = 1'b1;
		end
		r.x = trk_x[31:0];
		r.y = trk_y[31:0];
		r.hdg = trk_hdg;
		r.arr = trk_arrived;
		return r;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 8;
	int gap_left = 0;
	pose_cmd_t feed_cmd;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 8;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				pose_q.push_back(advance_pose({op, speed, duration, turn_angle}));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					feed_cmd = cmd_q.pop_front();
					in_valid <= 1'b1;
					op <= feed_cmd.op;
					speed <= feed_cmd.speed;
					duration <= feed_cmd.duration;
					turn_angle <= feed_cmd.turn_angle;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the stall pattern steps through four modes in turn, and once, well into
	// the run, it refuses every transfer for a long stretch.
	logic [8:0] rx_cycle = '0;
	int         hold_left = 0;
	bit         long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle <= '0;
			hold_left <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1'b1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 700) begin
				hold_left <= 600;
				long_hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else begin
				case (rx_cycle[8:7])
					2'd0:    out_ready <= 1'b1;
					2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
					2'd2:    out_ready <= (rx_cycle[1:0] == 2'd0);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("pose mismatch on %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	pose_rpt_t seen_exp;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (pose_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("pose result with none expected: x %0h y %0h hdg %0h arr %0b",
						pos_x, pos_y, heading, arrived);
			end else begin
				seen_exp = pose_q.pop_front();
				check_field("pos_x", seen_exp.x, pos_x);
				check_field("pos_y", seen_exp.y, pos_y);
				check_field("heading", seen_exp.hdg, heading);
				check_field("arrived", seen_exp.arr, arrived);
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			drpu_pkg::REG_TARGET_X:  goal_x = longint'($signed(val));
			drpu_pkg::REG_TARGET_Y:  goal_y = longint'($signed(val));
			drpu_pkg::REG_TOLERANCE: goal_tol = longint'(val[15:0]);
			default: ;
		endcase
	endtask

	// Waits until every queued command has been transferred and answered.
	task automatic settle();
		@(negedge clk);
		while (cmd_q.size() != 0 || in_valid || pose_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic pose_cmd_t mk(input logic [2:0] o, input logic [15:0] s,
			input logic [15:0] d, input logic [16:0] a);
		pose_cmd_t c;
		c.op = o;
		c.speed = s;
		c.duration = d;
		c.turn_angle = a;
		return c;
	endfunction

	function automatic pose_cmd_t random_cmd();
		pose_cmd_t   c;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 34)
			c.op = drpu_pkg::OP_DRIVE;
		else if (roll < 50)
			c.op = drpu_pkg::OP_REVERSE;
		else if (roll < 68)
			c.op = drpu_pkg::OP_RIGHT;
		else if (roll < 86)
			c.op = drpu_pkg::OP_LEFT;
		else if (roll < 93)
			c.op = drpu_pkg::OP_PARK;
		else
			c.op = drpu_pkg::OP_LEFT + 3'($urandom_range(1, 3));
		c.speed = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
		c.duration = ($urandom_range(0, 6) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 2047));
		roll = $urandom_range(0, 9);
		if (roll < 6)
			c.turn_angle = 17'($urandom_range(0, 92160) - 46080);
		else if (roll < 8)
			c.turn_angle = 17'(int'($urandom_range(0, 8)) * 5760 - 23040);
		else
			c.turn_angle = 17'($urandom);
		return c;
	endfunction

	// A long haul: one turn, then a run of near-full-scale moves in one sense,
	// enough to drive the position into saturation.
	task automatic queue_haul();
		pose_cmd_t c;
		c = random_cmd();
		c.op = ($urandom_range(0, 1) == 1) ? drpu_pkg::OP_LEFT : drpu_pkg::OP_RIGHT;
		cmd_q.push_back(c);
		c.op = ($urandom_range(0, 1) == 1) ? drpu_pkg::OP_DRIVE : drpu_pkg::OP_REVERSE;
		repeat (44) begin
			c.speed = 16'($urandom_range(58000, 65535));
			c.duration = 16'($urandom_range(58000, 65535));
			cmd_q.push_back(c);
		end
	endtask

	task automatic fill_random(input int count);
		while (cmd_q.size() < count) begin
			if ($urandom_range(0, 99) == 0)
				queue_haul();
			else
				cmd_q.push_back(random_cmd());
		end
	endtask

	initial begin
		trk_x = 0;
		trk_y = 0;
		trk_hdg = drpu_pkg::HEADING_RESET;
		trk_arrived = 1'b0;
		goal_x = 0;
		goal_y = 0;
		goal_tol = longint'(drpu_pkg::TOL_RESET);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		longint off_x, off_y;

		@(posedge arst_n);
		// The origin lies inside the reset window, so move the target away first.
		write_reg(drpu_pkg::REG_TARGET_X, 32'h7FFF_FFFF);
		write_reg(drpu_pkg::REG_TARGET_Y, 32'h8000_0000);
		write_reg(drpu_pkg::REG_TOLERANCE, 32'd0);

		cmd_q.push_back(mk(drpu_pkg::OP_PARK, 16'h0000, 16'h0000, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_DRIVE, 16'h0000, 16'h0000, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_DRIVE, 16'hFFFF, 16'hFFFF, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_REVERSE, 16'hFFFF, 16'hFFFF, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_DRIVE, 16'h0001, 16'hFFFF, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_LEFT, 16'h0000, 16'h0000, 17'sd46080));
		cmd_q.push_back(mk(drpu_pkg::OP_RIGHT, 16'h0000, 16'h0000, -17'sd46080));
		cmd_q.push_back(mk(drpu_pkg::OP_RIGHT, 16'h0000, 16'h0000, 17'sd11520));
		cmd_q.push_back(mk(drpu_pkg::OP_DRIVE, 16'h0040, 16'h0100, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_LEFT, 16'h0000, 16'h0000, 17'sd1));
		cmd_q.push_back(mk(drpu_pkg::OP_LEFT, 16'h0000, 16'h0000, -17'sd1));
		// Turn angles outside the documented range still convert and wrap.
		cmd_q.push_back(mk(drpu_pkg::OP_RIGHT, 16'h0000, 16'h0000, 17'h0FFFF));
		cmd_q.push_back(mk(drpu_pkg::OP_LEFT, 16'h0000, 16'h0000, 17'h10000));
		cmd_q.push_back(mk(drpu_pkg::OP_LEFT, 16'h0000, 16'h0000, 17'sd23040));
		cmd_q.push_back(mk(drpu_pkg::OP_DRIVE, 16'hFFFF, 16'h0001, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_REVERSE, 16'h5555, 16'hAAAA, 17'h00000));
		// Spare command codes behave as park.
		cmd_q.push_back(mk(drpu_pkg::OP_LEFT + 3'd1, 16'hFFFF, 16'hFFFF, 17'h1FFFF));
		cmd_q.push_back(mk(drpu_pkg::OP_LEFT + 3'd2, 16'hAAAA, 16'h5555, 17'sd5760));
		cmd_q.push_back(mk(drpu_pkg::OP_LEFT + 3'd3, 16'h5555, 16'hAAAA, -17'sd5760));
		cmd_q.push_back(mk(drpu_pkg::OP_RIGHT, 16'h0000, 16'h0000, 17'sd5760));
		cmd_q.push_back(mk(drpu_pkg::OP_DRIVE, 16'hAAAA, 16'h5555, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_REVERSE, 16'h0001, 16'h0001, 17'h00000));
		cmd_q.push_back(mk(drpu_pkg::OP_PARK, 16'hFFFF, 16'hFFFF, 17'h1FFFF));
		settle();

		write_reg(drpu_pkg::REG_TARGET_X, $urandom);
		write_reg(drpu_pkg::REG_TARGET_Y, $urandom);
		write_reg(drpu_pkg::REG_TOLERANCE, 32'h0000_FFFF);
		fill_random(540);
		settle();

		write_reg(drpu_pkg::REG_TARGET_X, 32'h8000_0000);
		write_reg(drpu_pkg::REG_TARGET_Y, $urandom);
		write_reg(drpu_pkg::REG_TOLERANCE, 32'd0);
		fill_random(540);
		settle();

		write_reg(drpu_pkg::REG_TARGET_X, $urandom);
		write_reg(drpu_pkg::REG_TARGET_Y, $urandom);
		write_reg(drpu_pkg::REG_TOLERANCE, 32'($urandom_range(0, 65535)));
		fill_random(540);
		settle();

		// Just outside the window on x: no arrival yet.
		off_x = (trk_x > 0) ? trk_x - 301 : trk_x + 301;
		write_reg(drpu_pkg::REG_TOLERANCE, 32'd300);
		write_reg(drpu_pkg::REG_TARGET_X, off_x[31:0]);
		write_reg(drpu_pkg::REG_TARGET_Y, trk_y[31:0]);
		cmd_q.push_back(mk(drpu_pkg::OP_PARK, 16'h0000, 16'h0000, 17'h00000));
		settle();

		// Exactly on the window edge on both axes: the bound is inclusive.
		off_x = (trk_x > 0) ? trk_x - 300 : trk_x + 300;
		off_y = (trk_y > 0) ? trk_y - 300 : trk_y + 300;
		write_reg(drpu_pkg::REG_TARGET_X, off_x[31:0]);
		write_reg(drpu_pkg::REG_TARGET_Y, off_y[31:0]);
		cmd_q.push_back(mk(drpu_pkg::OP_PARK, 16'h0000, 16'h0000, 17'h00000));
		settle();

		// Once arrived the pose is frozen, whatever the registers now say.
		write_reg(drpu_pkg::REG_TARGET_X, 32'h8000_0000);
		write_reg(drpu_pkg::REG_TARGET_Y, 32'h7FFF_FFFF);
		write_reg(drpu_pkg::REG_TOLERANCE, 32'd0);
		repeat (12)
			cmd_q.push_back(random_cmd());
		settle();

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#10ms;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/drpu_pkg.sv
sv/drpu_mul.sv
sv/drpu_cordic.sv
sv/dead_reckoning_pose_update.sv
sv/drpu_checker.sv
bench/testbench.sv
